// File: rtl/ipv6eh_pkg.sv
package ipv6eh_pkg;

  localparam logic [7:0] KIND_ROUTE = 8'd43;
  localparam logic [7:0] KIND_FRAG  = 8'd44;
  localparam logic [7:0] KIND_AH    = 8'd51;

  localparam logic [7:0] ROUTE_RH0 = 8'd0;
  localparam logic [7:0] ROUTE_RH2 = 8'd2;
  localparam logic [7:0] ROUTE_SRH = 8'd4;

  localparam logic [11:0] FIRST_ADDR_POS = 12'd8;
  localparam logic [11:0] AH_MIN_BYTES   = 12'd12;
  localparam logic [11:0] FRAG_BYTES     = 12'd8;
  localparam logic [11:0] FIXED_END_POS  = 12'd7;

  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 9;
  localparam int OUT_DATA_W = 248;
  localparam int OUT_USER_W = 2;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_EOF = 2'd1,
    ST_BAD = 2'd2
  } status_t;

  // declared high field first so that next_protocol packs into the lowest bits
  typedef struct packed {
    logic [31:0] security_index;
    logic [31:0] frag_ident;
    logic        more_frags;
    logic [12:0] frag_offset;
    logic [63:0] final_dst_lower;
    logic [63:0] final_dst_upper;
    logic        final_dst_valid;
    logic [7:0]  hops_remaining;
    logic [7:0]  route_kind;
    logic [11:0] header_bytes;
    logic [7:0]  next_protocol;
  } result_t;

  function automatic logic [15:0] swap16(input logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

// File: rtl/ipv6_extension_header_parser.sv
// channel  | dir | tdata                | tuser                          | tlast
// ---------+-----+----------------------+--------------------------------+---------------
// s_*      | in  | data_byte            | start_of_header, header_type   | last_available
// m_*      | out | header result fields | status                         | -
// cfg_*    | in  | byte_order (1 bit)   | -                              | -
//
// One byte per clock sustained while the output is not stalled; a byte enters the input
// register when accepted, and its result, if any, enters the result register when the byte
// leaves the input register. The two register stages are the input and result registers.
// rst is synchronous: clears valids, parse activity and byte_order.
// A stalled output holds the input register; s_tready drops only when both are full.
module ipv6_extension_header_parser (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_wr_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ipv6eh_pkg::IN_DATA_W-1:0]  s_tdata,  // [7:0] data_byte
  input  logic [ipv6eh_pkg::IN_USER_W-1:0]  s_tuser,  // [0] start_of_header, [8:1] header_type
  input  logic                              s_tlast,  // last_available
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [7:0] next_protocol, [19:8] header_bytes, [27:20] route_kind, [35:28] hops_remaining,
  // [36] final_dst_valid, [100:37] final_dst_upper, [164:101] final_dst_lower,
  // [177:165] frag_offset, [178] more_frags, [210:179] frag_ident,
  // [242:211] security_index, [247:243] zero
  output logic [ipv6eh_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [ipv6eh_pkg::OUT_USER_W-1:0] m_tuser   // [1:0] status
);
  import ipv6eh_pkg::*;

  // config
  logic byte_order;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;
  logic [7:0] in_kind;
  logic       in_last;

  // parse state
  logic         active;
  logic [11:0]  byte_pos;
  logic [7:0]   cur_kind;
  logic [7:0]   ext_len_byte;
  logic [11:0]  total_bytes;
  logic [7:0]   saved_next;
  logic [7:0]   saved_route;
  logic [7:0]   saved_hops;
  logic [11:0]  addr_start;
  logic [127:0] addr_buffer;
  logic [15:0]  frag_word;
  logic [31:0]  word32;

  // result register
  logic    out_valid;
  status_t out_status;
  result_t out_res;

  logic fire, go;

  // state as seen by this byte (a start byte begins from cleared state)
  logic [11:0] p;
  logic [7:0]  kind_c, ext_c, next_c, route_c, hops_c;
  logic [11:0] total_c, astart_c;
  logic [15:0] frag_c;
  logic [31:0] word_c;

  logic [7:0]   ext_next, saved_next_next, route_next, hops_next;
  logic [11:0]  total_next, astart_next;
  logic [15:0]  frag_next;
  logic [31:0]  word_next;
  logic [127:0] addr_next;
  logic [12:0]  astart_end;
  logic [12:0]  p_inc;

  logic    short_ah, done, addressed, bad_len, emit;
  status_t status_next;
  result_t res_next;
  logic [15:0] frag_ord;

  assign fire     = in_valid && (!out_valid || m_tready);
  assign go       = fire && (in_start || active);
  assign s_tready = !in_valid || fire;

  always_comb begin
    p        = in_start ? 12'd0 : byte_pos;
    kind_c   = in_start ? in_kind : cur_kind;
    ext_c    = in_start ? 8'd0 : ext_len_byte;
    next_c   = in_start ? 8'd0 : saved_next;
    route_c  = in_start ? 8'd0 : saved_route;
    hops_c   = in_start ? 8'd0 : saved_hops;
    total_c  = in_start ? 12'd0 : total_bytes;
    astart_c = in_start ? 12'd0 : addr_start;
    frag_c   = in_start ? 16'd0 : frag_word;
    word_c   = in_start ? 32'd0 : word32;

    saved_next_next = (p == 12'd0) ? in_byte : next_c;
    ext_next        = (p == 12'd1) ? in_byte : ext_c;
    total_next      = total_c;
    if (p == 12'd1) begin
      if (kind_c == KIND_FRAG) begin
        total_next = FRAG_BYTES;
      end else if (kind_c == KIND_AH) begin
        total_next = (12'(in_byte) + 12'd2) << 2;
      end else begin
        total_next = (12'(in_byte) + 12'd1) << 3;
      end
    end
    route_next  = (p == 12'd2) ? in_byte : route_c;
    hops_next   = (p == 12'd3) ? in_byte : hops_c;
    frag_next   = frag_c;
    astart_next = astart_c;
    if (p == 12'd2 || p == 12'd3) begin
      frag_next = {frag_c[7:0], in_byte};
      if (route_next == ROUTE_SRH || ext_next < 8'd2) begin
        astart_next = FIRST_ADDR_POS;
      end else begin
        // last address of the list: 8 + 16 * (len/2 - 1)
        astart_next = FIRST_ADDR_POS + {1'b0, ext_next[7:1] - 7'd1, 4'b0000};
      end
    end
    word_next = (p[11:2] == 10'd1) ? {word_c[23:0], in_byte} : word_c;

    astart_end = {1'b0, astart_next} + 13'd16;
    addr_next  = addr_buffer;
    if (p >= FIRST_ADDR_POS && kind_c == KIND_ROUTE && p >= astart_next &&
        {1'b0, p} < astart_end) begin
      addr_next = {addr_buffer[119:0], in_byte};
    end

    p_inc     = {1'b0, p} + 13'd1;
    short_ah  = (p == FIXED_END_POS) && (kind_c == KIND_AH) && (total_next < AH_MIN_BYTES);
    done      = (p >= FIXED_END_POS) && (p_inc == {1'b0, total_next});
    addressed = (kind_c == KIND_ROUTE) && (hops_next != 8'd0) &&
                (route_next == ROUTE_RH0 || route_next == ROUTE_RH2 ||
                 route_next == ROUTE_SRH);
    bad_len   = addressed && (ext_next < 8'd2 || ext_next[0]);
    emit      = go && (short_ah || done || in_last);

    frag_ord    = byte_order ? swap16(frag_next) : frag_next;
    res_next    = '0;
    status_next = ST_OK;
    if (short_ah) begin
      status_next = ST_BAD;
    end else if (done) begin
      if (bad_len) begin
        status_next = ST_BAD;
      end else begin
        res_next.next_protocol = saved_next_next;
        res_next.header_bytes  = total_next;
        if (kind_c == KIND_ROUTE) begin
          res_next.route_kind     = route_next;
          res_next.hops_remaining = hops_next;
          if (addressed) begin
            res_next.final_dst_valid = 1'b1;
            res_next.final_dst_upper = addr_next[127:64];
            res_next.final_dst_lower = addr_next[63:0];
          end
        end else if (kind_c == KIND_FRAG) begin
          res_next.frag_offset = frag_ord[15:3];
          res_next.more_frags  = frag_ord[0];
          res_next.frag_ident  = byte_order ? swap32(word_next) : word_next;
        end else if (kind_c == KIND_AH) begin
          res_next.security_index = byte_order ? swap32(word_next) : word_next;
        end
      end
    end else begin
      status_next = ST_EOF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_order <= 1'b0;
      in_valid   <= 1'b0;
      active     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        byte_order <= cfg_wr_data;
      end
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (fire) begin
        in_valid <= 1'b0;
      end
      if (go) begin
        active <= !(short_ah || done || in_last);
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata[7:0];
      in_start <= s_tuser[0];
      in_kind  <= s_tuser[8:1];
      in_last  <= s_tlast;
    end
    if (go) begin
      byte_pos     <= p_inc[11:0];
      cur_kind     <= kind_c;
      ext_len_byte <= ext_next;
      total_bytes  <= total_next;
      saved_next   <= saved_next_next;
      saved_route  <= route_next;
      saved_hops   <= hops_next;
      addr_start   <= astart_next;
      addr_buffer  <= addr_next;
      frag_word    <= frag_next;
      word32       <= word_next;
    end
    if (emit) begin
      out_status <= status_next;
      out_res    <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {5'b00000, out_res};

  // error items carry nothing but the status
  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_OK |-> out_res == '0)
    else $error("error item with payload");

  a_dst_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.final_dst_valid |-> out_status == ST_OK)
    else $error("destination on a failed header");

  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    emit |=> !active)
    else $error("parser still active after its result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && out_valid && !m_tready)
    else $error("input stalled without output backpressure");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (rst)
    fire && !in_start && !active |=> $stable(out_status) || !out_valid)
    else $error("item while idle changed the result");

endmodule
